FILE: rtl/core/rvie_pkg.sv
// shared types, constants and helpers for the rv32i instruction execute block
`timescale 1ns / 1ps

package rvie_pkg;

    localparam int unsigned MEM_WORDS = 4096;
    localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
    localparam logic [31:0] MEM_BYTES = 32'(MEM_WORDS * 4);

    localparam logic CFG_START_PC = 1'b0;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_PRIV   = 3'd0;
    localparam logic [2:0] F3_CSRRW  = 3'd1;
    localparam logic [2:0] F3_SYS_RSVD = 3'd4;

    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;

    localparam logic [11:0] CSR_MSTATUS   = 12'h300;
    localparam logic [11:0] CSR_MISA      = 12'h301;
    localparam logic [11:0] CSR_MIE       = 12'h304;
    localparam logic [11:0] CSR_MTVEC     = 12'h305;
    localparam logic [11:0] CSR_MSCRATCH  = 12'h340;
    localparam logic [11:0] CSR_MEPC      = 12'h341;
    localparam logic [11:0] CSR_MCAUSE    = 12'h342;
    localparam logic [11:0] CSR_MTVAL     = 12'h343;
    localparam logic [11:0] CSR_MIP       = 12'h344;
    localparam logic [11:0] CSR_CYCLE     = 12'hC00;
    localparam logic [11:0] CSR_MVENDORID = 12'hF11;

    localparam logic [31:0] MISA_RESET   = 32'h4040_1101;
    localparam logic [31:0] MVENDOR_RESET = 32'hFF0F_F0FF;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_PC_ALIGN = 3'd1,
        ERR_ILLEGAL  = 3'd2,
        ERR_EBREAK   = 3'd3,
        ERR_MEM      = 3'd4
    } err_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] value;
        logic        halt;
        err_t        err;
        logic        load;
        logic [2:0]  funct3;
        logic [1:0]  byte_off;
    } exec_res_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [MEM_AW-1:0] index;
        logic [31:0]       wdata;
        logic [31:0]       wmask;
    } mem_req_t;

    typedef struct packed {
        logic        en;
        logic [11:0] num;
        logic [31:0] data;
    } csr_req_t;

    function automatic logic [31:0] load_extract(input logic [31:0] word,
                                                 input logic [2:0]  funct3,
                                                 input logic [1:0]  off);
        logic [31:0] w;
        logic [31:0] r;
        w = word >> {off, 3'b000};
        unique case (funct3)
            F3_LB:   r = {{24{w[7]}}, w[7:0]};
            F3_LH:   r = {{16{w[15]}}, w[15:0]};
            F3_LBU:  r = {24'd0, w[7:0]};
            F3_LHU:  r = {16'd0, w[15:0]};
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/rvie_ram.sv
// generic single-write, single-read ram with bit write mask and registered read
`timescale 1ns / 1ps

module rvie_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [WIDTH-1:0]         wmask,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/rvie_csr_file.sv
// machine csr storage with swap access
`timescale 1ns / 1ps

module rvie_csr_file (
    input  logic              aclk,
    input  logic              aresetn,
    input  rvie_pkg::csr_req_t req,
    output logic [31:0]       rdata,
    output logic              hit
);

    localparam int unsigned NUM_CSR = 11;

    logic [31:0] csr_reg [NUM_CSR];
    logic [3:0]  sel;

    always_comb begin
        hit = 1'b1;
        unique case (req.num)
            rvie_pkg::CSR_MSTATUS:   sel = 4'd0;
            rvie_pkg::CSR_MISA:      sel = 4'd1;
            rvie_pkg::CSR_MIE:       sel = 4'd2;
            rvie_pkg::CSR_MTVEC:     sel = 4'd3;
            rvie_pkg::CSR_MSCRATCH:  sel = 4'd4;
            rvie_pkg::CSR_MEPC:      sel = 4'd5;
            rvie_pkg::CSR_MCAUSE:    sel = 4'd6;
            rvie_pkg::CSR_MTVAL:     sel = 4'd7;
            rvie_pkg::CSR_MIP:       sel = 4'd8;
            rvie_pkg::CSR_CYCLE:     sel = 4'd9;
            rvie_pkg::CSR_MVENDORID: sel = 4'd10;
            default: begin
                sel = 4'd0;
                hit = 1'b0;
            end
        endcase
        rdata = csr_reg[sel];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CSR; i++) begin
                csr_reg[i] <= '0;
            end
            csr_reg[1]  <= rvie_pkg::MISA_RESET;
            csr_reg[10] <= rvie_pkg::MVENDOR_RESET;
        end else if (req.en && hit) begin
            csr_reg[sel] <= req.data;
        end
    end

endmodule

FILE: rtl/core/rvie_exec.sv
// instruction decode, alu, branch and memory address logic
`timescale 1ns / 1ps

module rvie_exec (
    input  logic [31:0]          instr,
    input  logic [31:0]          pc,
    input  logic [31:0]          op_a,
    input  logic [31:0]          op_b,
    input  logic [31:0]          csr_rdata,
    input  logic                 csr_hit,
    output rvie_pkg::exec_res_t  res,
    output rvie_pkg::mem_req_t   mem_req,
    output rvie_pkg::csr_req_t   csr_req
);

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        alt;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] pc4;
    logic [31:0] alu_b;
    logic [4:0]  shamt;
    logic [31:0] alu_res;
    logic [31:0] addr_i;
    logic [31:0] addr;
    logic        aligned;
    logic        mem_ok;
    logic        take;
    logic        load;
    logic        store;
    logic        csr_wr;
    logic [4:0]  sh;

    assign opcode = instr[6:0];
    assign rd     = instr[11:7];
    assign f3     = instr[14:12];
    assign alt    = instr[30];
    assign imm_i  = {{20{instr[31]}}, instr[31:20]};
    assign imm_s  = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b  = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j  = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    assign imm_u  = {instr[31:12], 12'd0};
    assign pc4    = pc + 32'd4;
    assign alu_b  = (opcode == rvie_pkg::OPC_OP) ? op_b : imm_i;
    assign shamt  = alu_b[4:0];
    assign addr_i = op_a + imm_i;
    assign addr   = (opcode == rvie_pkg::OPC_STORE) ? (op_a + imm_s) : addr_i;
    assign sh     = {addr[1:0], 3'b000};

    always_comb begin
        unique case (f3[1:0])
            2'd0:    aligned = 1'b1;
            2'd1:    aligned = ~addr[0];
            default: aligned = (addr[1:0] == 2'd0);
        endcase
        mem_ok = aligned && (addr < rvie_pkg::MEM_BYTES);
    end

    always_comb begin
        unique case (f3)
            rvie_pkg::F3_ADD: begin
                alu_res = ((opcode == rvie_pkg::OPC_OP) && alt) ? (op_a - alu_b)
                                                               : (op_a + alu_b);
            end
            rvie_pkg::F3_SLL:  alu_res = op_a << shamt;
            rvie_pkg::F3_SLT:  alu_res = {31'd0, $signed(op_a) < $signed(alu_b)};
            rvie_pkg::F3_SLTU: alu_res = {31'd0, op_a < alu_b};
            rvie_pkg::F3_XOR:  alu_res = op_a ^ alu_b;
            rvie_pkg::F3_SR: begin
                alu_res = alt ? 32'($signed(op_a) >>> shamt) : (op_a >> shamt);
            end
            rvie_pkg::F3_OR:   alu_res = op_a | alu_b;
            default:           alu_res = op_a & alu_b;
        endcase
    end

    always_comb begin
        res          = '0;
        res.next_pc  = pc4;
        res.err      = rvie_pkg::ERR_NONE;
        res.funct3   = f3;
        res.byte_off = addr[1:0];
        load         = 1'b0;
        store        = 1'b0;
        csr_wr       = 1'b0;
        take         = 1'b0;
        if (pc[1:0] != 2'd0) begin
            res.err = rvie_pkg::ERR_PC_ALIGN;
        end else begin
            unique case (opcode)
                rvie_pkg::OPC_LUI: begin
                    res.wr    = 1'b1;
                    res.value = imm_u;
                end
                rvie_pkg::OPC_AUIPC: begin
                    res.wr    = 1'b1;
                    res.value = pc + imm_u;
                end
                rvie_pkg::OPC_JAL: begin
                    res.wr      = 1'b1;
                    res.value   = pc4;
                    res.next_pc = pc + imm_j;
                end
                rvie_pkg::OPC_JALR: begin
                    res.wr      = 1'b1;
                    res.value   = pc4;
                    res.next_pc = {addr_i[31:1], 1'b0};
                end
                rvie_pkg::OPC_BRANCH: begin
                    unique case (f3)
                        rvie_pkg::F3_BEQ:  take = (op_a == op_b);
                        rvie_pkg::F3_BNE:  take = (op_a != op_b);
                        rvie_pkg::F3_BLT:  take = ($signed(op_a) < $signed(op_b));
                        rvie_pkg::F3_BGE:  take = !($signed(op_a) < $signed(op_b));
                        rvie_pkg::F3_BLTU: take = (op_a < op_b);
                        rvie_pkg::F3_BGEU: take = (op_a >= op_b);
                        default:           res.err = rvie_pkg::ERR_ILLEGAL;
                    endcase
                    if (take) begin
                        res.next_pc = pc + imm_b;
                    end
                end
                rvie_pkg::OPC_LOAD: begin
                    if (!(f3 == rvie_pkg::F3_LB || f3 == rvie_pkg::F3_LH ||
                          f3 == rvie_pkg::F3_LW || f3 == rvie_pkg::F3_LBU ||
                          f3 == rvie_pkg::F3_LHU)) begin
                        res.err = rvie_pkg::ERR_ILLEGAL;
                    end else if (!mem_ok) begin
                        res.err = rvie_pkg::ERR_MEM;
                    end else begin
                        load   = 1'b1;
                        res.wr = 1'b1;
                    end
                end
                rvie_pkg::OPC_STORE: begin
                    if (f3 > 3'd2) begin
                        res.err = rvie_pkg::ERR_ILLEGAL;
                    end else if (!mem_ok) begin
                        res.err = rvie_pkg::ERR_MEM;
                    end else begin
                        store = 1'b1;
                    end
                end
                rvie_pkg::OPC_OPIMM, rvie_pkg::OPC_OP: begin
                    res.wr    = 1'b1;
                    res.value = alu_res;
                end
                rvie_pkg::OPC_FENCE: begin
                    res.wr = 1'b0;
                end
                rvie_pkg::OPC_SYSTEM: begin
                    if (f3 == rvie_pkg::F3_PRIV) begin
                        if (instr[31:20] == rvie_pkg::SYS_ECALL) begin
                            res.halt = 1'b1;
                        end else if (instr[31:20] == rvie_pkg::SYS_EBREAK) begin
                            res.err = rvie_pkg::ERR_EBREAK;
                        end else begin
                            res.err = rvie_pkg::ERR_ILLEGAL;
                        end
                    end else if (f3 == rvie_pkg::F3_CSRRW) begin
                        if (csr_hit) begin
                            csr_wr    = 1'b1;
                            res.wr    = 1'b1;
                            res.value = csr_rdata;
                        end
                    end else if (f3 == rvie_pkg::F3_SYS_RSVD) begin
                        res.err = rvie_pkg::ERR_ILLEGAL;
                    end
                end
                default: res.err = rvie_pkg::ERR_ILLEGAL;
            endcase
        end
        if (res.err != rvie_pkg::ERR_NONE) begin
            res.next_pc = pc;
            res.wr      = 1'b0;
            res.halt    = 1'b0;
            load        = 1'b0;
            store       = 1'b0;
            csr_wr      = 1'b0;
        end
        if (rd == 5'd0) begin
            res.wr = 1'b0;
        end
        res.rd    = res.wr ? rd : 5'd0;
        res.value = (res.wr && !load) ? res.value : 32'd0;
        res.load  = load && res.wr;
    end

    always_comb begin
        mem_req.wr_en = store;
        mem_req.rd_en = load;
        mem_req.index = addr[rvie_pkg::MEM_AW+1:2];
        mem_req.wdata = op_b << sh;
        unique case (f3[1:0])
            2'd0:    mem_req.wmask = 32'h0000_00FF << sh;
            2'd1:    mem_req.wmask = 32'h0000_FFFF << sh;
            default: mem_req.wmask = 32'hFFFF_FFFF;
        endcase
    end

    assign csr_req.en   = csr_wr;
    assign csr_req.num  = instr[31:20];
    assign csr_req.data = op_a;

endmodule

FILE: rtl/core/rv32i_instruction_execute.sv
// rv32i execute core: request register, execute stage, memory stage, result register
// throughput: one instruction per cycle unless m_ready stalls the pipeline;
// register values are forwarded from the memory stage
// reset: synchronous active-low; pc and start_pc clear to 0, csrs take their reset values
// after reset a clearing pass over all MEM_WORDS words zeroes data memory and registers
// s_ready stays low during the clearing pass; configuration writes are taken throughout
`timescale 1ns / 1ps

module rv32i_instruction_execute (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instruction_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_reg_write_valid,
    output logic [4:0]  m_reg_write_index,
    output logic [31:0] m_reg_write_value,
    output logic        m_halt_request,
    output logic [2:0]  m_error_code
);

    localparam int unsigned AW = rvie_pkg::MEM_AW;

    logic                clear_busy_reg;
    logic [AW-1:0]       clear_cnt_reg;
    logic [31:0]         start_pc_reg;
    logic [31:0]         pc_reg;

    logic                ex_valid_reg;
    logic [31:0]         ex_instr_reg;
    logic                fwd1_valid_reg;
    logic [31:0]         fwd1_value_reg;
    logic                fwd2_valid_reg;
    logic [31:0]         fwd2_value_reg;

    logic                mw_valid_reg;
    rvie_pkg::exec_res_t mw_res_reg;

    logic                out_valid_reg;
    logic [31:0]         out_next_pc_reg;
    logic                out_wr_reg;
    logic [4:0]          out_rd_reg;
    logic [31:0]         out_value_reg;
    logic                out_halt_reg;
    logic [2:0]          out_err_reg;

    logic                cfg_wr;
    logic                adv_out;
    logic                adv_mw;
    logic                adv_ex;
    logic                fire_ex;
    logic                accept;
    logic                wevent;
    logic [31:0]         mw_value;
    logic [31:0]         rf1_rdata;
    logic [31:0]         rf2_rdata;
    logic [31:0]         dmem_rdata;
    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic [31:0]         csr_rdata;
    logic                csr_hit;
    logic [4:0]          rs1;
    logic [4:0]          rs2;
    logic [4:0]          s_rs1;
    logic [4:0]          s_rs2;
    logic                rf_we;
    logic [4:0]          rf_waddr;
    logic [31:0]         rf_wdata;
    logic                dm_we;
    logic [AW-1:0]       dm_waddr;
    logic [31:0]         dm_wdata;
    logic [31:0]         dm_wmask;

    rvie_pkg::exec_res_t ex_res;
    rvie_pkg::mem_req_t  mem_req;
    rvie_pkg::csr_req_t  csr_req;
    rvie_pkg::csr_req_t  csr_req_gated;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rvie_pkg::CFG_START_PC);
    assign prdata = (paddr[2] == rvie_pkg::CFG_START_PC) ? start_pc_reg : 32'd0;

    assign adv_out = !out_valid_reg || m_ready;
    assign adv_mw  = !mw_valid_reg || adv_out;
    assign adv_ex  = !ex_valid_reg || adv_mw;
    assign fire_ex = ex_valid_reg && adv_mw;
    assign s_ready = adv_ex && !clear_busy_reg;
    assign accept  = s_valid && s_ready;

    assign mw_value = mw_res_reg.load
        ? rvie_pkg::load_extract(dmem_rdata, mw_res_reg.funct3, mw_res_reg.byte_off)
        : mw_res_reg.value;
    assign wevent = mw_valid_reg && adv_out && mw_res_reg.wr;

    assign rs1   = ex_instr_reg[19:15];
    assign rs2   = ex_instr_reg[24:20];
    assign s_rs1 = s_instruction_word[19:15];
    assign s_rs2 = s_instruction_word[24:20];

    always_comb begin
        priority if (mw_valid_reg && mw_res_reg.wr && (mw_res_reg.rd == rs1)) begin
            op_a = mw_value;
        end else if (fwd1_valid_reg) begin
            op_a = fwd1_value_reg;
        end else begin
            op_a = rf1_rdata;
        end
        priority if (mw_valid_reg && mw_res_reg.wr && (mw_res_reg.rd == rs2)) begin
            op_b = mw_value;
        end else if (fwd2_valid_reg) begin
            op_b = fwd2_value_reg;
        end else begin
            op_b = rf2_rdata;
        end
    end

    rvie_exec u_exec (
        .instr     (ex_instr_reg),
        .pc        (pc_reg),
        .op_a      (op_a),
        .op_b      (op_b),
        .csr_rdata (csr_rdata),
        .csr_hit   (csr_hit),
        .res       (ex_res),
        .mem_req   (mem_req),
        .csr_req   (csr_req)
    );

    always_comb begin
        csr_req_gated    = csr_req;
        csr_req_gated.en = csr_req.en && fire_ex;
    end

    rvie_csr_file u_csr_file (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (csr_req_gated),
        .rdata   (csr_rdata),
        .hit     (csr_hit)
    );

    assign rf_we    = clear_busy_reg || wevent;
    assign rf_waddr = clear_busy_reg ? clear_cnt_reg[4:0] : mw_res_reg.rd;
    assign rf_wdata = clear_busy_reg ? 32'd0 : mw_value;

    rvie_ram #(.WIDTH(32), .DEPTH(32)) u_regfile_a (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .wmask ('1),
        .re    (accept),
        .raddr (s_rs1),
        .rdata (rf1_rdata)
    );

    rvie_ram #(.WIDTH(32), .DEPTH(32)) u_regfile_b (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .wmask ('1),
        .re    (accept),
        .raddr (s_rs2),
        .rdata (rf2_rdata)
    );

    assign dm_we    = clear_busy_reg || (fire_ex && mem_req.wr_en);
    assign dm_waddr = clear_busy_reg ? clear_cnt_reg : mem_req.index;
    assign dm_wdata = clear_busy_reg ? 32'd0 : mem_req.wdata;
    assign dm_wmask = clear_busy_reg ? 32'hFFFF_FFFF : mem_req.wmask;

    rvie_ram #(.WIDTH(32), .DEPTH(rvie_pkg::MEM_WORDS)) u_dmem (
        .aclk  (aclk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .wmask (dm_wmask),
        .re    (fire_ex && mem_req.rd_en),
        .raddr (mem_req.index),
        .rdata (dmem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
        end else if (clear_busy_reg) begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == AW'(rvie_pkg::MEM_WORDS - 1)) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pc_reg <= 32'd0;
            pc_reg       <= 32'd0;
        end else if (cfg_wr) begin
            start_pc_reg <= pwdata;
            pc_reg       <= pwdata;
        end else if (fire_ex) begin
            pc_reg <= ex_res.next_pc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg   <= 1'b0;
            fwd1_valid_reg <= 1'b0;
            fwd2_valid_reg <= 1'b0;
        end else if (adv_ex) begin
            ex_valid_reg   <= accept;
            fwd1_valid_reg <= accept && wevent && (mw_res_reg.rd == s_rs1);
            fwd2_valid_reg <= accept && wevent && (mw_res_reg.rd == s_rs2);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_instr_reg   <= s_instruction_word;
            fwd1_value_reg <= mw_value;
            fwd2_value_reg <= mw_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mw_valid_reg <= 1'b0;
        end else if (adv_mw) begin
            mw_valid_reg <= ex_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_mw) begin
            mw_res_reg <= ex_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv_out) begin
            out_valid_reg <= mw_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            out_next_pc_reg <= mw_res_reg.next_pc;
            out_wr_reg      <= mw_res_reg.wr;
            out_rd_reg      <= mw_res_reg.rd;
            out_value_reg   <= mw_value;
            out_halt_reg    <= mw_res_reg.halt;
            out_err_reg     <= mw_res_reg.err;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_next_pc         = out_next_pc_reg;
    assign m_reg_write_valid = out_wr_reg;
    assign m_reg_write_index = out_rd_reg;
    assign m_reg_write_value = out_value_reg;
    assign m_halt_request    = out_halt_reg;
    assign m_error_code      = out_err_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !s_ready)
        else $error("request accepted during clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        wevent |-> (mw_res_reg.rd != 5'd0))
        else $error("register write to x0");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!fire_ex && !cfg_wr) |=> $stable(pc_reg))
        else $error("pc changed without an executed request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire_ex |=> mw_valid_reg)
        else $error("executed request lost before memory stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_err_reg != rvie_pkg::ERR_NONE)) |->
            (!out_wr_reg && !out_halt_reg))
        else $error("faulting request has side effects");

endmodule

FILE: tb/tb.sv
// testbench for the rv32i execute core: directed and random streams checked by a predictor
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] ADDR_START_PC = 3'd0;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 50;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        logic [31:0]    next_pc;
        logic           wv;
        logic [4:0]     idx;
        logic [31:0]    val;
        logic           halt;
        rvie_pkg::err_t err;
    } retire_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic [31:0] s_instruction_word;
    logic        m_valid, m_ready;
    logic [31:0] m_next_pc;
    logic        m_reg_write_valid;
    logic [4:0]  m_reg_write_index;
    logic [31:0] m_reg_write_value;
    logic        m_halt_request;
    logic [2:0]  m_error_code;

    logic [31:0] instr_q[$];
    retire_t     retire_q[$];
    int          errors = 0;
    int          cycles = 0;
    logic        calm = 1'b0;

    // architectural copy
    logic [31:0] pc_m;
    logic [31:0] regs_m[32];
    logic [31:0] csrs_m[11];
    logic [31:0] mem_m[rvie_pkg::MEM_WORDS];

    rv32i_instruction_execute i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int csr_index(input logic [11:0] num);
        case (num)
            rvie_pkg::CSR_MSTATUS:   return 0;
            rvie_pkg::CSR_MISA:      return 1;
            rvie_pkg::CSR_MIE:       return 2;
            rvie_pkg::CSR_MTVEC:     return 3;
            rvie_pkg::CSR_MSCRATCH:  return 4;
            rvie_pkg::CSR_MEPC:      return 5;
            rvie_pkg::CSR_MCAUSE:    return 6;
            rvie_pkg::CSR_MTVAL:     return 7;
            rvie_pkg::CSR_MIP:       return 8;
            rvie_pkg::CSR_CYCLE:     return 9;
            rvie_pkg::CSR_MVENDORID: return 10;
            default:                 return -1;
        endcase
    endfunction

    function automatic logic fits(input logic [31:0] addr, input int size);
        if (({1'b0, addr} + 33'(size)) > {1'b0, rvie_pkg::MEM_BYTES}) return 1'b0;
        return (addr & 32'(size - 1)) == 32'd0;
    endfunction

    task automatic execute_instr(input logic [31:0] ins);
        logic [31:0]    pc, npc, a, b, val, imm, addr, w, m;
        logic [4:0]     rd;
        logic [2:0]     f3;
        logic           alt, wr, halt, take;
        rvie_pkg::err_t err;
        int             size, ci;
        retire_t        r;
        pc = pc_m; npc = pc + 32'd4; rd = ins[11:7]; f3 = ins[14:12];
        a = regs_m[ins[19:15]]; b = regs_m[ins[24:20]]; alt = ins[30];
        wr = 1'b0; val = 32'd0; halt = 1'b0; take = 1'b0; err = rvie_pkg::ERR_NONE;
        if (pc[1:0] != 2'b00) begin
            err = rvie_pkg::ERR_PC_ALIGN;
        end else begin
            case (ins[6:0])
                rvie_pkg::OPC_LUI: begin wr = 1'b1; val = {ins[31:12], 12'd0}; end
                rvie_pkg::OPC_AUIPC: begin wr = 1'b1; val = pc + {ins[31:12], 12'd0}; end
                rvie_pkg::OPC_JAL: begin
                    imm = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
                    wr = 1'b1; val = pc + 32'd4; npc = pc + imm;
                end
                rvie_pkg::OPC_JALR: begin
                    wr = 1'b1; val = pc + 32'd4;
                    npc = (a + {{20{ins[31]}}, ins[31:20]}) & 32'hFFFF_FFFE;
                end
                rvie_pkg::OPC_BRANCH: begin
                    imm = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
                    case (f3)
                        rvie_pkg::F3_BEQ:  take = a == b;
                        rvie_pkg::F3_BNE:  take = a != b;
                        rvie_pkg::F3_BLT:  take = $signed(a) < $signed(b);
                        rvie_pkg::F3_BGE:  take = !($signed(a) < $signed(b));
                        rvie_pkg::F3_BLTU: take = a < b;
                        rvie_pkg::F3_BGEU: take = a >= b;
                        default: begin take = 1'b0; err = rvie_pkg::ERR_ILLEGAL; end
                    endcase
                    if (take) npc = pc + imm;
                end
                rvie_pkg::OPC_LOAD: begin
                    addr = a + {{20{ins[31]}}, ins[31:20]};
                    size = (f3[1:0] == 2'd0) ? 1 : ((f3[1:0] == 2'd1) ? 2 : 4);
                    if (f3 == 3'd3 || f3 > rvie_pkg::F3_LHU) err = rvie_pkg::ERR_ILLEGAL;
                    else if (!fits(addr, size)) err = rvie_pkg::ERR_MEM;
                    else begin
                        w = mem_m[addr[rvie_pkg::MEM_AW+1:2]] >> {addr[1:0], 3'b000};
                        case (f3)
                            rvie_pkg::F3_LB:  val = {{24{w[7]}}, w[7:0]};
                            rvie_pkg::F3_LH:  val = {{16{w[15]}}, w[15:0]};
                            rvie_pkg::F3_LBU: val = {24'd0, w[7:0]};
                            rvie_pkg::F3_LHU: val = {16'd0, w[15:0]};
                            default:          val = w;
                        endcase
                        wr = 1'b1;
                    end
                end
                rvie_pkg::OPC_STORE: begin
                    addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                    size = (f3 == 3'd0) ? 1 : ((f3 == 3'd1) ? 2 : 4);
                    if (f3 > 3'd2) err = rvie_pkg::ERR_ILLEGAL;
                    else if (!fits(addr, size)) err = rvie_pkg::ERR_MEM;
                    else begin
                        m = (size == 4) ? 32'hFFFF_FFFF :
                            (((32'd1 << (size * 8)) - 32'd1) << {addr[1:0], 3'b000});
                        mem_m[addr[rvie_pkg::MEM_AW+1:2]] =
                            (mem_m[addr[rvie_pkg::MEM_AW+1:2]] & ~m) |
                            ((b << {addr[1:0], 3'b000}) & m);
                    end
                end
                rvie_pkg::OPC_OPIMM: begin
                    imm = {{20{ins[31]}}, ins[31:20]};
                    wr = 1'b1;
                    case (f3)
                        rvie_pkg::F3_ADD:  val = a + imm;
                        rvie_pkg::F3_SLL:  val = a << imm[4:0];
                        rvie_pkg::F3_SLT:  val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
                        rvie_pkg::F3_SLTU: val = (a < imm) ? 32'd1 : 32'd0;
                        rvie_pkg::F3_XOR:  val = a ^ imm;
                        rvie_pkg::F3_SR:
                            val = alt ? 32'($signed(a) >>> imm[4:0]) : a >> imm[4:0];
                        rvie_pkg::F3_OR:   val = a | imm;
                        default:           val = a & imm;
                    endcase
                end
                rvie_pkg::OPC_OP: begin
                    wr = 1'b1;
                    case (f3)
                        rvie_pkg::F3_ADD:  val = alt ? a - b : a + b;
                        rvie_pkg::F3_SLL:  val = a << b[4:0];
                        rvie_pkg::F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        rvie_pkg::F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
                        rvie_pkg::F3_XOR:  val = a ^ b;
                        rvie_pkg::F3_SR:
                            val = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
                        rvie_pkg::F3_OR:   val = a | b;
                        default:           val = a & b;
                    endcase
                end
                rvie_pkg::OPC_FENCE: ;
                rvie_pkg::OPC_SYSTEM: begin
                    if (f3 == rvie_pkg::F3_PRIV) begin
                        if (ins[31:20] == rvie_pkg::SYS_ECALL) halt = 1'b1;
                        else if (ins[31:20] == rvie_pkg::SYS_EBREAK) err = rvie_pkg::ERR_EBREAK;
                        else err = rvie_pkg::ERR_ILLEGAL;
                    end else if (f3 == rvie_pkg::F3_CSRRW) begin
                        ci = csr_index(ins[31:20]);
                        if (ci >= 0) begin
                            val = csrs_m[ci]; csrs_m[ci] = a; wr = 1'b1;
                        end
                    end else if (f3 == rvie_pkg::F3_SYS_RSVD) begin
                        err = rvie_pkg::ERR_ILLEGAL;
                    end
                end
                default: err = rvie_pkg::ERR_ILLEGAL;
            endcase
        end
        if (err != rvie_pkg::ERR_NONE) begin
            npc = pc; wr = 1'b0; halt = 1'b0;
        end
        if (rd == 5'd0) wr = 1'b0;
        if (wr) regs_m[rd] = val;
        regs_m[0] = 32'd0;
        pc_m = npc;
        r.next_pc = npc; r.wv = wr; r.idx = wr ? rd : 5'd0; r.val = wr ? val : 32'd0;
        r.halt = halt; r.err = err;
        retire_q.push_back(r);
    endtask

    function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                          input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], rvie_pkg::OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, rvie_pkg::OPC_OP};
    endfunction

    function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvie_pkg::OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvie_pkg::OPC_JAL};
    endfunction

    function automatic logic [4:0] rnd_reg();
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] random_instr();
        int          sel, size;
        logic [2:0]  f3;
        logic [11:0] imm;
        logic [11:0] csr_list[11];
        csr_list = '{rvie_pkg::CSR_MSTATUS, rvie_pkg::CSR_MISA, rvie_pkg::CSR_MIE,
                     rvie_pkg::CSR_MTVEC, rvie_pkg::CSR_MSCRATCH, rvie_pkg::CSR_MEPC,
                     rvie_pkg::CSR_MCAUSE, rvie_pkg::CSR_MTVAL, rvie_pkg::CSR_MIP,
                     rvie_pkg::CSR_CYCLE, rvie_pkg::CSR_MVENDORID};
        sel = $urandom_range(0, 99);
        if (sel < 8) return {20'($urandom), rnd_reg(), rvie_pkg::OPC_LUI};
        if (sel < 12) return {20'($urandom), rnd_reg(), rvie_pkg::OPC_AUIPC};
        if (sel < 27) begin
            f3 = 3'($urandom);
            imm = 12'($urandom);
            if (f3 == rvie_pkg::F3_SLL || f3 == rvie_pkg::F3_SR)
                imm = {1'b0, 1'($urandom), 5'd0, 5'($urandom)};
            if ($urandom_range(0, 9) == 0) imm = 12'($urandom);
            return enc_i(rvie_pkg::OPC_OPIMM, rnd_reg(), f3, rnd_reg(), imm);
        end
        if (sel < 42) return enc_r(7'($urandom), rnd_reg(), rnd_reg(), 3'($urandom), rnd_reg());
        if (sel < 53 || (sel >= 95)) begin
            case ($urandom_range(0, 4))
                0: f3 = rvie_pkg::F3_LB; 1: f3 = rvie_pkg::F3_LH; 2: f3 = rvie_pkg::F3_LW;
                3: f3 = rvie_pkg::F3_LBU;
                default: f3 = rvie_pkg::F3_LHU;
            endcase
            size = (f3[1:0] == 2'd0) ? 1 : ((f3[1:0] == 2'd1) ? 2 : 4);
            imm = 12'($urandom_range(0, 2047));
            if ($urandom_range(0, 6) != 0) imm = imm & ~12'(size - 1);
            if (sel >= 95)
                return enc_i(rvie_pkg::OPC_LOAD, rnd_reg(), f3, rnd_reg(), 12'($urandom));
            return enc_i(rvie_pkg::OPC_LOAD, rnd_reg(), f3, 5'd0, imm);
        end
        if (sel < 64) begin
            f3 = 3'($urandom_range(0, 2));
            size = (f3 == 3'd0) ? 1 : ((f3 == 3'd1) ? 2 : 4);
            imm = 12'($urandom_range(0, 2047));
            if ($urandom_range(0, 6) != 0) imm = imm & ~12'(size - 1);
            if ($urandom_range(0, 9) == 0) return enc_s(f3, rnd_reg(), rnd_reg(), 12'($urandom));
            return enc_s(f3, 5'd0, rnd_reg(), imm);
        end
        if (sel < 72) begin
            case ($urandom_range(0, 5))
                0: f3 = rvie_pkg::F3_BEQ; 1: f3 = rvie_pkg::F3_BNE; 2: f3 = rvie_pkg::F3_BLT;
                3: f3 = rvie_pkg::F3_BGE; 4: f3 = rvie_pkg::F3_BLTU;
                default: f3 = rvie_pkg::F3_BGEU;
            endcase
            return enc_b(f3, rnd_reg(), rnd_reg(), {11'($urandom), 2'b00});
        end
        if (sel < 76) return enc_j(rnd_reg(), {19'($urandom), 2'b00});
        if (sel < 79) return enc_i(rvie_pkg::OPC_JALR, rnd_reg(), 3'($urandom), 5'd0,
                                   {10'($urandom), 2'b00});
        if (sel < 84) begin
            f3 = ($urandom_range(0, 3) == 0) ? 3'($urandom) : rvie_pkg::F3_CSRRW;
            if (f3 == rvie_pkg::F3_PRIV || f3 == rvie_pkg::F3_SYS_RSVD) f3 = rvie_pkg::F3_CSRRW;
            imm = ($urandom_range(0, 7) == 0) ? 12'($urandom) : csr_list[$urandom_range(0, 10)];
            return enc_i(rvie_pkg::OPC_SYSTEM, rnd_reg(), f3, rnd_reg(), imm);
        end
        if (sel < 87) return enc_i(rvie_pkg::OPC_SYSTEM, 5'd0, rvie_pkg::F3_PRIV, 5'd0,
                                   ($urandom_range(0, 2) == 0) ? rvie_pkg::SYS_EBREAK
                                                               : rvie_pkg::SYS_ECALL);
        if (sel < 89) return {25'($urandom), rvie_pkg::OPC_FENCE};
        return $urandom;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic cfg_write(input logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_START_PC; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pc_m = v;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (instr_q.size() != 0 || retire_q.size() != 0 || s_valid) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid            <= 1'b0;
            s_instruction_word <= '0;
            m_ready            <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 16);
            if (!s_valid || s_ready) begin
                if (instr_q.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
                    s_valid <= 1'b1;
                    s_instruction_word <= instr_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        retire_t e;
        if (aresetn) begin
            if (s_valid && s_ready) execute_instr(s_instruction_word);
            if (m_valid && m_ready) begin
                if (retire_q.size() == 0) begin
                    report("unexpected request", m_next_pc, 32'd0);
                end else begin
                    e = retire_q.pop_front();
                    if (m_next_pc !== e.next_pc) report("next_pc", m_next_pc, e.next_pc);
                    if (m_reg_write_valid !== e.wv) report("reg_write_valid",
                        32'(m_reg_write_valid), 32'(e.wv));
                    if (m_reg_write_index !== e.idx) report("reg_write_index",
                        32'(m_reg_write_index), 32'(e.idx));
                    if (m_reg_write_value !== e.val) report("reg_write_value",
                        m_reg_write_value, e.val);
                    if (m_halt_request !== e.halt) report("halt_request",
                        32'(m_halt_request), 32'(e.halt));
                    if (m_error_code !== e.err) report("error_code",
                        32'(m_error_code), 32'(e.err));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int          sent;
        int          n;
        logic [31:0] spc;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        pc_m = 32'd0;
        foreach (regs_m[i]) regs_m[i] = 32'd0;
        foreach (csrs_m[i]) csrs_m[i] = 32'd0;
        csrs_m[1] = rvie_pkg::MISA_RESET;
        csrs_m[10] = rvie_pkg::MVENDOR_RESET;
        foreach (mem_m[i]) mem_m[i] = 32'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        cfg_write(32'd0);

        // directed
        calm = 1'b1;
        instr_q.push_back({20'hFFFFF, 5'd1, rvie_pkg::OPC_LUI});
        instr_q.push_back(enc_i(rvie_pkg::OPC_OPIMM, 5'd2, rvie_pkg::F3_ADD, 5'd0, 12'h800));
        instr_q.push_back(enc_i(rvie_pkg::OPC_OPIMM, 5'd3, rvie_pkg::F3_ADD, 5'd0, 12'h7FF));
        instr_q.push_back({20'd4, 5'd5, rvie_pkg::OPC_LUI});
        instr_q.push_back(enc_i(rvie_pkg::OPC_OPIMM, 5'd5, rvie_pkg::F3_ADD, 5'd5, 12'hFFC));
        instr_q.push_back(enc_s(3'd2, 5'd5, 5'd2, 12'd0));
        instr_q.push_back(enc_i(rvie_pkg::OPC_LOAD, 5'd6, rvie_pkg::F3_LW, 5'd5, 12'd0));
        instr_q.push_back(enc_i(rvie_pkg::OPC_LOAD, 5'd7, rvie_pkg::F3_LB, 5'd5, 12'd3));
        instr_q.push_back(enc_i(rvie_pkg::OPC_LOAD, 5'd8, rvie_pkg::F3_LBU, 5'd5, 12'd3));
        instr_q.push_back(enc_i(rvie_pkg::OPC_LOAD, 5'd9, rvie_pkg::F3_LH, 5'd5, 12'd2));
        instr_q.push_back(enc_i(rvie_pkg::OPC_LOAD, 5'd10, rvie_pkg::F3_LHU, 5'd5, 12'd2));
        instr_q.push_back(enc_i(rvie_pkg::OPC_LOAD, 5'd11, rvie_pkg::F3_LW, 5'd5, 12'd4));
        instr_q.push_back(enc_i(rvie_pkg::OPC_LOAD, 5'd0, rvie_pkg::F3_LH, 5'd0, 12'd1));
        instr_q.push_back(enc_r(7'h20, 5'd3, 5'd2, rvie_pkg::F3_ADD, 5'd12));
        instr_q.push_back(enc_r(7'h20, 5'd3, 5'd1, rvie_pkg::F3_SR, 5'd13));
        instr_q.push_back(enc_i(rvie_pkg::OPC_OPIMM, 5'd14, rvie_pkg::F3_SR, 5'd1, 12'h41F));
        instr_q.push_back(enc_b(3'd2, 5'd0, 5'd0, 13'd8));
        instr_q.push_back(enc_i(rvie_pkg::OPC_LOAD, 5'd4, 3'd3, 5'd0, 12'd0));
        instr_q.push_back(enc_s(3'd3, 5'd0, 5'd1, 12'd0));
        instr_q.push_back(enc_i(rvie_pkg::OPC_SYSTEM, 5'd1, rvie_pkg::F3_SYS_RSVD, 5'd0,
                                12'd0));
        instr_q.push_back(enc_i(rvie_pkg::OPC_SYSTEM, 5'd0, rvie_pkg::F3_PRIV, 5'd0,
                                rvie_pkg::SYS_ECALL));
        instr_q.push_back(enc_i(rvie_pkg::OPC_SYSTEM, 5'd0, rvie_pkg::F3_PRIV, 5'd0,
                                rvie_pkg::SYS_EBREAK));
        instr_q.push_back(enc_i(rvie_pkg::OPC_SYSTEM, 5'd0, rvie_pkg::F3_PRIV, 5'd0, 12'd2));
        instr_q.push_back(enc_i(rvie_pkg::OPC_SYSTEM, 5'd15, rvie_pkg::F3_CSRRW, 5'd3,
                                rvie_pkg::CSR_MISA));
        instr_q.push_back(enc_i(rvie_pkg::OPC_SYSTEM, 5'd16, rvie_pkg::F3_CSRRW, 5'd3,
                                12'h123));
        instr_q.push_back({25'h1ABCDEF, rvie_pkg::OPC_FENCE});
        instr_q.push_back(32'd0);
        instr_q.push_back(enc_b(rvie_pkg::F3_BEQ, 5'd0, 5'd0, 13'd8));
        instr_q.push_back(enc_i(rvie_pkg::OPC_JALR, 5'd1, 3'd0, 5'd0, 12'd6));
        instr_q.push_back(enc_i(rvie_pkg::OPC_OPIMM, 5'd1, rvie_pkg::F3_ADD, 5'd0, 12'd1));
        drain();

        // random phases, each from a fresh start_pc
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: spc = 32'hFFFF_FFFC;
                1: spc = 32'd0;
                2: spc = 32'hFFFF_FFFF;
                default: spc = $urandom & 32'hFFFF_FFFC;
            endcase
            cfg_write(spc);
            calm = ($urandom_range(0, 5) == 0);
            n = (spc[1:0] != 2'b00) ? 4 : PHASE_ITEMS;
            repeat (n) instr_q.push_back(random_instr());
            sent += n;
            drain();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
